[hw/rtl/kwce_pkg.sv]
// Shared constants, control struct and character functions for the k-mer extractor.
package kwce_pkg;

  // Window depth in characters
  localparam int KMaxDefault = 32;

  // Configuration register indexes
  localparam logic RegKmerLen = 1'b0;
  localparam logic RegCanonMode = 1'b1;

  // Reset values of the configuration registers
  localparam logic [5:0] KmerLenReset = 6'd21;
  localparam logic CanonModeReset = 1'b0;

  // Nucleotide codes in upper case ASCII, the lower-case letter bounds and the case gap
  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChG = 8'h47;
  localparam logic [7:0] ChT = 8'h54;
  localparam logic [7:0] ChN = 8'h4E;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowZ = 8'h7A;
  localparam logic [7:0] CaseGap = 8'h20;

  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

  // Control sent along the cell row
  typedef struct packed {
    logic shift_win;  // push a new character into the window
    logic load_work;  // copy the window into both work chains
    logic step_work;  // advance both work chains by one cell
  } kwce_ctrl_t;

  // Upper-case ASCII letters a..z, pass everything else
  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= ChLowA && c <= ChLowZ) begin
      r = c - CaseGap;
    end
    return r;
  endfunction

  // Complement of an upper-case base, zero when not a base
  function automatic logic [7:0] complement(input logic [7:0] u);
    logic [7:0] r;
    case (u)
      ChA: r = ChT;
      ChC: r = ChG;
      ChG: r = ChC;
      ChT: r = ChA;
      ChN: r = ChN;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/kwce_cell.sv]
// One window cell: a stored character plus one forward and one reverse work byte.
module kwce_cell (
  input  logic               clk_i,
  input  kwce_pkg::kwce_ctrl_t ctrl_i,
  input  logic [7:0]         win_from_i,
  input  logic [7:0]         fwd_from_i,
  input  logic [7:0]         rev_from_i,
  output logic [7:0]         win_o,
  output logic [7:0]         fwd_o,
  output logic [7:0]         rev_o
);
  import kwce_pkg::*;

  logic [7:0] win_q, win_d;
  logic [7:0] fwd_q, fwd_d;
  logic [7:0] rev_q, rev_d;

  // Shift the window toward the older end; copy or advance the work bytes
  always_comb begin
    win_d = ctrl_i.shift_win ? win_from_i : win_q;
    fwd_d = fwd_q;
    rev_d = rev_q;
    if (ctrl_i.load_work) begin
      fwd_d = win_q;
      rev_d = win_q;
    end else if (ctrl_i.step_work) begin
      fwd_d = fwd_from_i;
      rev_d = rev_from_i;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    fwd_q <= fwd_d;
    rev_q <= rev_d;
  end

  assign win_o = win_q;
  assign fwd_o = fwd_q;
  assign rev_o = rev_q;

endmodule

[hw/rtl/kmer_window_canonical_extractor.sv]
// Top level: k-mer window extractor with optional canonical (reverse complement) output.
//
// Characters enter one per item into a row of K_MAX cells. From the k-th
// character of the current sequence on, each item yields the k-mer ending
// at it, one character per result, kmer_last on the final one. In canonical
// mode a window that holds a non-base character sends a single null result
// instead. The work chains in the cell row move one cell per cycle while
// comparing, and while sending only when the output slot is free: a canonical
// k-mer is walked once to compare forward against reverse complement and
// once more to send it. Output stalls hold the walk; the next item is taken
// while the last result still waits in the output register.
module kmer_window_canonical_extractor #(
  parameter int K_MAX = kwce_pkg::KMaxDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [5:0]  cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  base_char_i,
  input  logic        seq_start_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] kmer_pos_o,
  output logic [7:0]  kmer_char_o,
  output logic        kmer_null_o,
  output logic        kmer_last_o
);
  import kwce_pkg::*;

  localparam int KW = $clog2(K_MAX + 1);
  localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_NULL = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [5:0]    kmer_len_q;
  logic          canon_q;
  logic [31:0]   cnt_q, cnt_d;
  logic [31:0]   pos_q, pos_d;
  logic [KW-1:0] j_q, j_d;
  logic          cmp_done_q, cmp_done_d;
  logic          decided_q, decided_d;
  logic          pick_rev_q, pick_rev_d;
  logic          bad_q, bad_d;

  logic          out_valid_q;
  logic [31:0]   out_pos_q;
  logic [7:0]    out_char_q;
  logic          out_null_q;
  logic          out_last_q;

  logic [KW-1:0] keff;
  logic [IW-1:0] tap_idx;
  logic [KW-1:0] tap_full;
  logic          in_acc;
  logic          slot_free;
  logic          out_load;
  logic [7:0]    out_char_d;
  logic          out_null_d;
  logic          out_last_d;
  logic [31:0]   cnt_base;
  logic          j_last;
  logic [7:0]    fwd_tap, rev_tap, fwd_up, rev_cmp, emit_char;
  kwce_ctrl_t    ctrl;

  logic [7:0] win_w [K_MAX];
  logic [7:0] fwd_w [K_MAX];
  logic [7:0] rev_w [K_MAX];

  // Effective window length: zero acts as one, clip at the depth
  always_comb begin
    if (kmer_len_q == 6'd0) begin
      keff = KW'(1);
    end else if (int'(kmer_len_q) > K_MAX) begin
      keff = KW'(K_MAX);
    end else begin
      keff = KW'(kmer_len_q);
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q <= KmerLenReset;
      canon_q    <= CanonModeReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKmerLen:   kmer_len_q <= cfg_wdata_i;
        RegCanonMode: canon_q    <= cfg_wdata_i[0];
        default:      kmer_len_q <= kmer_len_q;
      endcase
    end
  end

  // Cell row: newest character enters at the top cell
  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    logic [7:0] win_from, fwd_from, rev_from;
    if (i == K_MAX - 1) begin : g_top
      assign win_from = base_char_i;
      assign fwd_from = 8'h00;
    end else begin : g_mid
      assign win_from = win_w[i+1];
      assign fwd_from = fwd_w[i+1];
    end
    if (i == 0) begin : g_bot
      assign rev_from = 8'h00;
    end else begin : g_up
      assign rev_from = rev_w[i-1];
    end
    kwce_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .win_from_i (win_from),
      .fwd_from_i (fwd_from),
      .rev_from_i (rev_from),
      .win_o      (win_w[i]),
      .fwd_o      (fwd_w[i]),
      .rev_o      (rev_w[i])
    );
  end

  // Forward chain read at the oldest k-mer cell, reverse chain at the newest
  assign tap_full = KW'(K_MAX) - keff;
  assign tap_idx  = tap_full[IW-1:0];
  assign fwd_tap  = fwd_w[tap_idx];
  assign rev_tap  = rev_w[K_MAX-1];
  assign fwd_up   = to_upper(fwd_tap);
  assign rev_cmp  = complement(to_upper(rev_tap));

  always_comb begin
    if (!canon_q) begin
      emit_char = fwd_tap;
    end else if (pick_rev_q) begin
      emit_char = rev_cmp;
    end else begin
      emit_char = fwd_up;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign j_last     = (j_q == keff - KW'(1));
  assign cnt_base   = seq_start_i ? 32'd0 : cnt_q;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    j_d        = j_q;
    cmp_done_d = cmp_done_q;
    decided_d  = decided_q;
    pick_rev_d = pick_rev_q;
    bad_d      = bad_q;
    ctrl       = '0;
    out_load   = 1'b0;
    out_char_d = emit_char;
    out_null_d = 1'b0;
    out_last_d = j_last;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ctrl.shift_win = 1'b1;
          cnt_d      = (cnt_base == CountMax) ? cnt_base : cnt_base + 32'd1;
          pos_d      = cnt_d - 32'(keff) + 32'd1;
          cmp_done_d = 1'b0;
          if (cnt_d >= 32'(keff)) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        ctrl.load_work = 1'b1;
        j_d = '0;
        if (canon_q && !cmp_done_q) begin
          decided_d  = 1'b0;
          pick_rev_d = 1'b0;
          bad_d      = 1'b0;
          state_d    = ST_CMP;
        end else if (canon_q && bad_q) begin
          state_d = ST_NULL;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_CMP: begin
        // Walk forward and reverse complement side by side; first difference decides
        ctrl.step_work = 1'b1;
        j_d = j_q + KW'(1);
        if (complement(fwd_up) == 8'h00) begin
          bad_d = 1'b1;
        end
        if (!decided_q && (fwd_up != rev_cmp)) begin
          decided_d  = 1'b1;
          pick_rev_d = (rev_cmp < fwd_up);
        end
        if (j_last) begin
          cmp_done_d = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load       = 1'b1;
          ctrl.step_work = 1'b1;
          j_d = j_q + KW'(1);
          if (j_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_NULL: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_char_d = 8'h00;
          out_null_d = 1'b1;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      j_q         <= '0;
      cmp_done_q  <= 1'b0;
      decided_q   <= 1'b0;
      pick_rev_q  <= 1'b0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      j_q        <= j_d;
      cmp_done_q <= cmp_done_d;
      decided_q  <= decided_d;
      pick_rev_q <= pick_rev_d;
      bad_q      <= bad_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold position and output payload
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (out_load) begin
      out_pos_q  <= pos_q;
      out_char_q <= out_char_d;
      out_null_q <= out_null_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kmer_pos_o  = out_pos_q;
  assign kmer_char_o = out_char_q;
  assign kmer_null_o = out_null_q;
  assign kmer_last_o = out_last_q;

  // Saturated counter stays saturated within a sequence
  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !seq_start_i && cnt_q == CountMax) |=> (cnt_q == CountMax))
    else $error("character counter left saturation");

  // Compare and emission index never reaches the window length
  a_j_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT || state_q == ST_CMP) |-> (j_q < keff))
    else $error("k-mer index out of range");

  // Last character sent returns the block to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> (state_q == ST_IDLE))
    else $error("sequencer busy after last result");

  // Null result is a lone, empty last item
  a_null_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kmer_null_o) |-> (kmer_last_o && kmer_char_o == 8'h00))
    else $error("malformed null result");

  // A null result only follows a completed canonical compare
  a_null_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NULL) |-> (canon_q && cmp_done_q && bad_q))
    else $error("null result without invalid canonical window");

endmodule

[sim/tb.sv]
// Self-checking testbench for the k-mer window extractor: directed table, then random phases.
`timescale 1ns / 100ps

module tb;
  import kwce_pkg::*;

  localparam int KDepth = KMaxDefault;
  localparam int ClkPeriod = 12;
  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 2 * KDepth + 8;
  localparam int PhaseItems = 54;
  localparam int NumPhases = 8;
  localparam int LongHoldCycles = 600;

  typedef struct packed {
    logic [31:0] pos;
    logic [7:0]  chr;
    logic        nul;
    logic        last;
  } kmer_out_t;

  typedef enum logic {RowCfg, RowItem} row_kind_e;

  // One row of the directed table: a register write or an item
  typedef struct {
    row_kind_e  kind;
    logic       cfg_idx;
    logic [5:0] cfg_val;
    logic [7:0] ch;
    logic       st;
    int         typed_n;  // -1: use the window model, 0: no result, 1: one typed result
    kmer_out_t  typed;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [5:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  base_char_i;
  logic        seq_start_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] kmer_pos_o;
  logic [7:0]  kmer_char_o;
  logic        kmer_null_o;
  logic        kmer_last_o;

  // Window model state and register copies
  logic [7:0]  win_m [KDepth];
  logic [31:0] chars_seen_m;
  logic [5:0]  kmer_len_m;
  logic        canon_m;

  kmer_out_t kmer_chars_due [$];
  int        err_count = 0;
  int        cycle_count = 0;
  int        sender_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        phase_idx = -1;
  int        hold_left = 0;
  bit        long_hold_done = 1'b0;

  kmer_window_canonical_extractor #(
    .K_MAX(KDepth)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .base_char_i (base_char_i),
    .seq_start_i (seq_start_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kmer_pos_o  (kmer_pos_o),
    .kmer_char_o (kmer_char_o),
    .kmer_null_o (kmer_null_o),
    .kmer_last_o (kmer_last_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Shift one character into the window and list the k-mer it completes
  function automatic void window_kmer(input logic [7:0] ch, input logic st,
                                      ref kmer_out_t res[$]);
    int unsigned k;
    int unsigned base_idx;
    int          j;
    int          order;
    bit          bad;
    logic [31:0] pos;
    logic [7:0]  u;
    logic [7:0]  c;
    logic [7:0]  fwd [KDepth];
    logic [7:0]  rev [KDepth];
    res.delete();
    if (st) chars_seen_m = '0;
    for (j = 0; j < KDepth - 1; j++) win_m[j] = win_m[j + 1];
    win_m[KDepth - 1] = ch;
    if (chars_seen_m != CountMax) chars_seen_m = chars_seen_m + 1;
    if (kmer_len_m == 0) k = 1;
    else if (kmer_len_m > KDepth) k = KDepth;
    else k = kmer_len_m;
    if (chars_seen_m < k) return;
    pos = chars_seen_m - k + 1;
    base_idx = KDepth - k;
    if (!canon_m) begin
      for (j = 0; j < k; j++) res.push_back('{pos, win_m[base_idx + j], 1'b0, j == k - 1});
      return;
    end
    // Upper-case, check each base, and build the reverse complement
    bad = 1'b0;
    for (j = 0; j < k; j++) begin
      u = win_m[base_idx + j];
      if (u >= ChLowA && u <= ChLowZ) u = u - CaseGap;
      case (u)
        ChA: c = ChT;
        ChC: c = ChG;
        ChG: c = ChC;
        ChT: c = ChA;
        ChN: c = ChN;
        default: c = 8'h00;
      endcase
      if (c == 8'h00) bad = 1'b1;
      fwd[j] = u;
      rev[k - 1 - j] = c;
    end
    if (bad) begin
      res.push_back('{pos, 8'h00, 1'b1, 1'b1});
      return;
    end
    // Forward wins ties
    order = 0;
    for (j = 0; j < k; j++) begin
      if (order == 0 && fwd[j] != rev[j]) order = (fwd[j] < rev[j]) ? -1 : 1;
    end
    for (j = 0; j < k; j++) begin
      res.push_back('{pos, (order <= 0) ? fwd[j] : rev[j], 1'b0, j == k - 1});
    end
  endfunction

  function automatic dir_row_t cfg_row(input logic idx, input logic [5:0] val);
    dir_row_t r;
    r.kind = RowCfg;
    r.cfg_idx = idx;
    r.cfg_val = val;
    r.ch = 8'h00;
    r.st = 1'b0;
    r.typed_n = 0;
    r.typed = '0;
    return r;
  endfunction

  function automatic dir_row_t item_row(input logic [7:0] ch, input logic st, input int n,
                                        input logic [31:0] pos, input logic [7:0] chr,
                                        input logic nul);
    dir_row_t r;
    r.kind = RowItem;
    r.cfg_idx = RegKmerLen;
    r.cfg_val = '0;
    r.ch = ch;
    r.st = st;
    r.typed_n = n;
    r.typed = '{pos, chr, nul, 1'b1};
    return r;
  endfunction

  // Offer one item, with random gaps first, and hold it until accepted
  task automatic offer_item(input logic [7:0] ch, input logic st);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    base_char_i <= ch;
    seq_start_i <= st;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drain the block, let it settle, then write one register
  task automatic write_register(input logic idx, input logic [5:0] val);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (kmer_chars_due.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegKmerLen) kmer_len_m = val;
    else canon_m = val[0];
  endtask

  // Receiver: random stalls, plus one long hold-off to back the block up
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (phase_idx == 1 && !long_hold_done && out_valid_o) begin
      out_stall_i <= 1'b1;
      hold_left <= LongHoldCycles;
      long_hold_done <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest one due
  always @(posedge clk_i) begin : check_results
    kmer_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (kmer_chars_due.size() == 0) begin
        $error("unexpected result: pos %0d char %h null %b last %b",
               kmer_pos_o, kmer_char_o, kmer_null_o, kmer_last_o);
        err_count++;
      end else begin
        want = kmer_chars_due.pop_front();
        if (want.pos !== kmer_pos_o) begin
          $error("kmer_pos: expected %0d, got %0d", want.pos, kmer_pos_o);
          err_count++;
        end
        if (want.chr !== kmer_char_o) begin
          $error("kmer_char: expected %h, got %h", want.chr, kmer_char_o);
          err_count++;
        end
        if (want.nul !== kmer_null_o) begin
          $error("kmer_null: expected %b, got %b", want.nul, kmer_null_o);
          err_count++;
        end
        if (want.last !== kmer_last_o) begin
          $error("kmer_last: expected %b, got %b", want.last, kmer_last_o);
          err_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("kmer_window_canonical_extractor: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t    dir_rows [$];
    kmer_out_t   got [$];
    logic [7:0]  alphabet [10];
    int          phase_k [NumPhases];
    bit          phase_canon [NumPhases];
    int          p;
    int          n;
    logic [7:0]  ch;
    logic        st;

    alphabet = '{ChA, ChC, ChG, ChT, ChN,
                 ChA + CaseGap, ChC + CaseGap, ChG + CaseGap, ChT + CaseGap, ChN + CaseGap};
    phase_k = '{32, 5, 63, 1, 32, 0, 12, 2};
    phase_canon = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegKmerLen;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    base_char_i = 8'h00;
    seq_start_i = 1'b0;
    for (n = 0; n < KDepth; n++) win_m[n] = 8'h00;
    chars_seen_m = '0;
    kmer_len_m = KmerLenReset;
    canon_m = CanonModeReset;

    // After reset k is 21: a single character fills nothing
    dir_rows.push_back(item_row(ChA, 1'b1, 0, 0, 8'h00, 1'b0));
    // Shortest window, plain mode, extreme bytes
    dir_rows.push_back(cfg_row(RegKmerLen, 6'd1));
    dir_rows.push_back(item_row(8'hFF, 1'b0, 1, 2, 8'hFF, 1'b0));
    dir_rows.push_back(item_row(8'h00, 1'b1, 1, 1, 8'h00, 1'b0));
    dir_rows.push_back(item_row(8'h80, 1'b0, 1, 2, 8'h80, 1'b0));
    // Canonical, one base: lower case, complement, invalid, N
    dir_rows.push_back(cfg_row(RegCanonMode, 6'd1));
    dir_rows.push_back(item_row(ChA + CaseGap, 1'b0, 1, 3, ChA, 1'b0));
    dir_rows.push_back(item_row(ChT + CaseGap, 1'b0, 1, 4, ChA, 1'b0));
    dir_rows.push_back(item_row(8'h78, 1'b0, 1, 5, 8'h00, 1'b1));
    dir_rows.push_back(item_row(ChN, 1'b0, 1, 6, ChN, 1'b0));
    // Length zero behaves as one; bytes just outside a..z are invalid
    dir_rows.push_back(cfg_row(RegKmerLen, 6'd0));
    dir_rows.push_back(item_row(ChG + CaseGap, 1'b1, 1, 1, ChC, 1'b0));
    dir_rows.push_back(item_row(ChLowZ + 8'h01, 1'b0, 1, 2, 8'h00, 1'b1));
    dir_rows.push_back(item_row(ChLowA - 8'h01, 1'b0, 1, 3, 8'h00, 1'b1));
    // k of 4: palindrome tie, then an invalid base inside the window
    dir_rows.push_back(cfg_row(RegKmerLen, 6'd4));
    dir_rows.push_back(item_row(ChA, 1'b1, 0, 0, 8'h00, 1'b0));
    dir_rows.push_back(item_row(ChC, 1'b0, 0, 0, 8'h00, 1'b0));
    dir_rows.push_back(item_row(ChG, 1'b0, 0, 0, 8'h00, 1'b0));
    dir_rows.push_back(item_row(ChT, 1'b0, -1, 0, 8'h00, 1'b0));
    dir_rows.push_back(item_row(ChA + CaseGap, 1'b0, -1, 0, 8'h00, 1'b0));
    dir_rows.push_back(item_row(8'h5A, 1'b0, 1, 3, 8'h00, 1'b1));
    dir_rows.push_back(item_row(ChG + CaseGap, 1'b0, 1, 4, 8'h00, 1'b1));
    // Plain k of 2, then a new sequence mid-stream
    dir_rows.push_back(cfg_row(RegCanonMode, 6'd0));
    dir_rows.push_back(cfg_row(RegKmerLen, 6'd2));
    dir_rows.push_back(item_row(ChT + CaseGap, 1'b0, -1, 0, 8'h00, 1'b0));
    dir_rows.push_back(item_row(ChC, 1'b1, 0, 0, 8'h00, 1'b0));
    dir_rows.push_back(item_row(ChG + CaseGap, 1'b0, -1, 0, 8'h00, 1'b0));

    sender_idle_pct = 20;
    recv_idle_pct = 57;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowCfg) begin
        write_register(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      end else begin
        offer_item(dir_rows[i].ch, dir_rows[i].st);
        window_kmer(dir_rows[i].ch, dir_rows[i].st, got);
        if (dir_rows[i].typed_n < 0) begin
          foreach (got[j]) kmer_chars_due.push_back(got[j]);
        end else if (dir_rows[i].typed_n == 1) begin
          kmer_chars_due.push_back(dir_rows[i].typed);
        end
      end
    end

    // Random phases: mostly bases with random case, some raw bytes
    for (p = 0; p < NumPhases; p++) begin
      if (p < 3) begin
        sender_idle_pct = 20;
        recv_idle_pct = 57;
      end else if (p < 6) begin
        sender_idle_pct = 57;
        recv_idle_pct = 20;
      end else begin
        sender_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_register(RegKmerLen, 6'(phase_k[p]));
      write_register(RegCanonMode, {5'd0, phase_canon[p]});
      phase_idx = p;
      for (n = 0; n < PhaseItems; n++) begin
        // Hold the sender once until every result is out
        if (p == 4 && n == PhaseItems / 2) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (kmer_chars_due.size() != 0);
        end
        st = (n == 0) || ($urandom_range(0, 39) == 0);
        if ($urandom_range(0, 99) < (canon_m ? 2 : 12)) ch = 8'($urandom_range(0, 255));
        else ch = alphabet[$urandom_range(0, 9)];
        offer_item(ch, st);
        window_kmer(ch, st, got);
        foreach (got[j]) kmer_chars_due.push_back(got[j]);
      end
    end

    // Wait for the last results, then watch for strays
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (kmer_chars_due.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("kmer_window_canonical_extractor: match");
    end else begin
      $display("kmer_window_canonical_extractor: mismatch");
    end
    $finish;
  end

endmodule
